// File: sv/dcf_pkg.sv
// Package for the display command framer: field widths, operation codes,
// command bytes and the frame record passed from front to back. No dependencies.
package dcf_pkg;

    localparam int OP_W = 4;

    typedef enum logic [3:0] {
        OP_CHAR    = 4'd0,
        OP_CLEAR   = 4'd1,
        OP_BRIGHT  = 4'd2,
        OP_COLOR   = 4'd3,
        OP_BG      = 4'd4,
        OP_CLR_BG  = 4'd5,
        OP_DOT     = 4'd6,
        OP_LINE    = 4'd7,
        OP_BOX     = 4'd8,
        OP_CIRCLE  = 4'd9,
        OP_BMP     = 4'd10,
        OP_BAUD    = 4'd11,
        OP_NUM     = 4'd12,
        OP_LOCATE  = 4'd13,
        OP_NEWLINE = 4'd14,
        OP_NONE    = 4'd15
    } op_t;

    localparam logic [7:0] FRAME_SOF     = 8'h55;
    localparam logic [7:0] FRAME_EOF     = 8'hAA;
    localparam logic [7:0] CMD_CHAR      = 8'h0B;
    localparam logic [7:0] CMD_CLEAR     = 8'h80;
    localparam logic [7:0] CMD_BRIGHT    = 8'h89;
    localparam logic [7:0] CMD_COLOR     = 8'h84;
    localparam logic [7:0] CMD_BG        = 8'h85;
    localparam logic [7:0] CMD_DOT       = 8'h01;
    localparam logic [7:0] CMD_LINE      = 8'h02;
    localparam logic [7:0] CMD_BOX       = 8'h03;
    localparam logic [7:0] CMD_BOX_FILL  = 8'h04;
    localparam logic [7:0] CMD_CIRC      = 8'h05;
    localparam logic [7:0] CMD_CIRC_FILL = 8'h06;
    localparam logic [7:0] CMD_BMP       = 8'h09;
    localparam logic [7:0] CMD_BAUD      = 8'h8B;
    localparam logic [7:0] CMD_NUM       = 8'h0A;
    localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
    localparam logic [31:0] BRIGHT_MAX   = 32'd500;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 1'd1;

    // Up to ten payload bytes, longest payload first byte in slot 0
    localparam int PAY_MAX = 10;
    localparam int PAY_CNT_W = 4;

    typedef struct packed {
        logic [7:0]              cmd;
        logic [PAY_CNT_W-1:0]    count;
        logic [PAY_MAX*8-1:0]    payload;
    } frame_t;

endpackage

// File: sv/dcf_if.sv
// Valid/ready channel interfaces for the display command framer.
// Depends on nothing.
interface dcf_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] operation;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic [31:0] value;
    logic       fill;
    logic [7:0] digit_count;
    logic [1:0] number_style;

    modport source (output valid, operation, pos_x, pos_y, end_x, end_y, value, fill,
                    digit_count, number_style, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, end_x, end_y, value, fill,
                    digit_count, number_style, output ready);
endinterface

interface dcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, tx_byte, frame_end, input ready);
    modport sink   (input valid, tx_byte, frame_end, output ready);
endinterface

// File: sv/dcf_front.sv
// Front end: accepts operations, keeps the text cursor, builds the frame record.
// Depends on dcf_pkg and dcf_in_if.
module dcf_front (
    input  logic                clk,
    input  logic                rst_n,
    dcf_in_if.sink              in_ch,
    input  logic [4:0]          text_columns,
    input  logic [4:0]          text_rows,
    output logic                push,
    output dcf_pkg::frame_t     frame,
    input  logic                full
);
    import dcf_pkg::*;

    logic [3:0] cursor_row_reg, cursor_row_next;
    logic [3:0] cursor_col_reg, cursor_col_next;
    logic [4:0] col_lim, row_lim;
    logic [4:0] row_inc, col_inc;
    logic [3:0] row_adv;
    logic       accept;
    logic [7:0] cmd;
    logic [PAY_CNT_W-1:0] cnt;
    logic [PAY_MAX*8-1:0] pay;
    logic [15:0] bright;
    logic [7:0] ch;

    assign in_ch.ready = !full;
    assign accept = in_ch.valid && !full;
    assign ch = in_ch.value[7:0];

    // Clamp register values to 1..16
    always_comb
    begin
        col_lim = (text_columns == 5'd0) ? 5'd1 : (text_columns > 5'd16 ? 5'd16 : text_columns);
        row_lim = (text_rows == 5'd0) ? 5'd1 : (text_rows > 5'd16 ? 5'd16 : text_rows);
        row_inc = {1'b0, cursor_row_reg} + 5'd1;
        row_adv = (row_inc >= row_lim) ? 4'd0 : row_inc[3:0];
        col_inc = {1'b0, cursor_col_reg} + 5'd1;
        bright  = (in_ch.value > BRIGHT_MAX) ? BRIGHT_MAX[15:0] : in_ch.value[15:0];
    end

    // Classify the operation into command, payload and cursor update
    always_comb
    begin
        cmd = 8'd0;
        cnt = '0;
        pay = '0;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        push = 1'b0;
        case (op_t'(in_ch.operation))
            OP_CHAR:
            begin
                if (ch == NEWLINE_CHAR)
                begin
                    cursor_col_next = 4'd0;
                    cursor_row_next = row_adv;
                end
                else
                begin
                    push = 1'b1;
                    cmd = CMD_CHAR;
                    cnt = 4'd5;
                    pay[79:40] = {9'd0, cursor_col_reg, 3'd0, 8'd0, cursor_row_reg, 4'd0, ch};
                    if (col_inc >= col_lim)
                    begin
                        cursor_col_next = 4'd0;
                        cursor_row_next = row_adv;
                    end
                    else
                    begin
                        cursor_col_next = col_inc[3:0];
                    end
                end
            end
            OP_CLEAR:
            begin
                push = 1'b1;
                cmd = CMD_CLEAR;
                cnt = 4'd1;
                pay[79:72] = FRAME_SOF;
                cursor_row_next = 4'd0;
                cursor_col_next = 4'd0;
            end
            OP_BRIGHT:
            begin
                push = 1'b1;
                cmd = CMD_BRIGHT;
                cnt = 4'd2;
                pay[79:64] = bright;
            end
            OP_COLOR:
            begin
                push = 1'b1;
                cmd = CMD_COLOR;
                cnt = 4'd2;
                pay[79:64] = in_ch.value[15:0];
            end
            OP_BG:
            begin
                push = 1'b1;
                cmd = CMD_BG;
                cnt = 4'd3;
                pay[79:56] = {8'h01, in_ch.value[15:0]};
            end
            OP_CLR_BG:
            begin
                push = 1'b1;
                cmd = CMD_BG;
                cnt = 4'd3;
            end
            OP_DOT:
            begin
                push = 1'b1;
                cmd = CMD_DOT;
                cnt = 4'd4;
                pay[79:48] = {8'd0, in_ch.pos_x, 8'd0, in_ch.pos_y};
            end
            OP_LINE, OP_BOX:
            begin
                push = 1'b1;
                if (op_t'(in_ch.operation) == OP_LINE)
                    cmd = CMD_LINE;
                else
                    cmd = in_ch.fill ? CMD_BOX_FILL : CMD_BOX;
                cnt = 4'd8;
                pay[79:16] = {8'd0, in_ch.pos_x, 8'd0, in_ch.pos_y,
                              8'd0, in_ch.end_x, 8'd0, in_ch.end_y};
            end
            OP_CIRCLE, OP_BMP:
            begin
                push = 1'b1;
                if (op_t'(in_ch.operation) == OP_BMP)
                    cmd = CMD_BMP;
                else
                    cmd = in_ch.fill ? CMD_CIRC_FILL : CMD_CIRC;
                cnt = 4'd6;
                pay[79:32] = {8'd0, in_ch.pos_x, 8'd0, in_ch.pos_y, 8'd0, ch};
            end
            OP_BAUD:
            begin
                push = 1'b1;
                cmd = CMD_BAUD;
                cnt = 4'd4;
                pay[79:48] = in_ch.value;
            end
            OP_NUM:
            begin
                push = 1'b1;
                cmd = CMD_NUM;
                cnt = 4'd10;
                pay = {8'd0, in_ch.pos_x[4:0], 3'd0, 8'd0, in_ch.pos_y[3:0], 4'd0,
                       in_ch.value, in_ch.digit_count, 6'd0, in_ch.number_style};
            end
            OP_LOCATE:
            begin
                cursor_row_next = ({1'b0, in_ch.pos_y} > {4'd0, row_lim - 5'd1})
                                  ? 4'(row_lim - 5'd1) : in_ch.pos_y[3:0];
                cursor_col_next = ({1'b0, in_ch.pos_x} > {4'd0, col_lim - 5'd1})
                                  ? 4'(col_lim - 5'd1) : in_ch.pos_x[3:0];
            end
            OP_NEWLINE:
            begin
                cursor_col_next = 4'd0;
                cursor_row_next = row_adv;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        if (!accept)
        begin
            push = 1'b0;
            cursor_row_next = cursor_row_reg;
            cursor_col_next = cursor_col_reg;
        end
    end

    assign frame.cmd = cmd;
    assign frame.count = cnt;
    assign frame.payload = pay;

    // Hold the text cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= 4'd0;
            cursor_col_reg <= 4'd0;
        end
        else
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end
endmodule

// File: sv/dcf_queue.sv
// Two-entry frame record queue between front and back.
// Depends on dcf_pkg.
module dcf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dcf_pkg::frame_t push_data,
    output logic            full,
    input  logic            pop,
    output dcf_pkg::frame_t pop_data,
    output logic            not_empty
);
    import dcf_pkg::*;

    frame_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Store pushed records
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: sv/dcf_back.sv
// Back end: serializes one frame record into bytes with sum and end markers.
// Depends on dcf_pkg and dcf_out_if.
module dcf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dcf_pkg::frame_t frame,
    input  logic            frame_valid,
    output logic            pop,
    dcf_out_if.source       out_ch
);
    import dcf_pkg::*;

    logic [4:0] byte_position_reg, byte_position_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] cur_byte;
    logic       last;
    logic [4:0] pay_idx;
    logic [7:0] pay_byte;
    logic       step;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign step = frame_valid && slot_free;
    assign pay_idx = byte_position_reg - 5'd3;
    assign pay_byte = frame.payload[(PAY_MAX*8-1) - 8*pay_idx[3:0] -: 8];

    // Pick the byte at the current position
    always_comb
    begin
        last = 1'b0;
        sum_next = sum_reg;
        if (byte_position_reg == 5'd0)
            cur_byte = FRAME_SOF;
        else if (byte_position_reg == 5'd1)
            cur_byte = {3'd0, frame.count + 4'd1};
        else if (byte_position_reg == 5'd2)
        begin
            cur_byte = frame.cmd;
            sum_next = frame.cmd;
        end
        else if (byte_position_reg < {1'b0, frame.count} + 5'd3)
        begin
            cur_byte = pay_byte;
            sum_next = sum_reg + pay_byte;
        end
        else if (byte_position_reg == {1'b0, frame.count} + 5'd3)
            cur_byte = sum_reg;
        else
        begin
            cur_byte = FRAME_EOF;
            last = 1'b1;
        end
        byte_position_next = last ? 5'd0 : byte_position_reg + 5'd1;
    end

    assign pop = step && last;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.tx_byte = out_byte_reg;
    assign out_ch.frame_end = out_end_reg;

    // Advance position and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 5'd0;
            sum_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                byte_position_reg <= byte_position_next;
                sum_reg <= sum_next;
            end
            if (slot_free)
                out_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg <= last;
        end
    end
endmodule

// File: sv/display_command_framer_core.sv
// Display command framer top level: front end, two-entry queue, byte serializer.
// The operation is written into the queue; the serializer then registers each frame byte for output.
// Throughput: one byte per cycle while the receiver is ready; a frame of n payload bytes
// is n + 5 bytes long; the front takes an item per cycle while the queue has room.
// Reset clears the cursor, the queue and the serializer; registers go to 16 columns, 10 rows.
module display_command_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    dcf_in_if.sink      in_ch,
    dcf_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [4:0]  cfg_data
);
    import dcf_pkg::*;

    logic [4:0] text_columns_reg;
    logic [4:0] text_rows_reg;
    logic       push, full, pop, not_empty;
    frame_t     f_in, f_out;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_columns_reg <= 5'd16;
            text_rows_reg <= 5'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEXT_COLUMNS: text_columns_reg <= cfg_data;
                REG_TEXT_ROWS:    text_rows_reg <= cfg_data;
                default:          text_rows_reg <= text_rows_reg;
            endcase
        end
    end

    dcf_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .text_columns(text_columns_reg), .text_rows(text_rows_reg),
        .push(push), .frame(f_in), .full(full)
    );

    dcf_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(f_in), .full(full),
        .pop(pop), .pop_data(f_out), .not_empty(not_empty)
    );

    dcf_back u_back (
        .clk(clk), .rst_n(rst_n), .frame(f_out), .frame_valid(not_empty),
        .pop(pop), .out_ch(out_ch)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full)) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("pop from empty queue");
    a_end_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_ch.valid && out_ch.frame_end)) else $error("frame end missing");
endmodule

// File: tb/dcf_tb_if.sv
// Testbench copy point for channel interfaces: none needed beyond the RTL's dcf_if.sv.
// Depends on nothing; holds the byte record type used by the scoreboard.
package dcf_tb_pkg;
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } frame_byte_t;
endpackage

// File: tb/tb_display_command_framer_core.sv
// Testbench for display_command_framer_core: drives display operations and register
// writes, predicts every frame byte and checks the serial output in order.
// Depends on dcf_pkg, dcf_tb_pkg and the channel interfaces in dcf_if.sv.
module tb_display_command_framer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import dcf_pkg::*;
    import dcf_tb_pkg::*;

    // Scoreboard: frame predictor plus queue of expected bytes
    class frame_scoreboard;
        logic [4:0]  columns_reg;
        logic [4:0]  rows_reg;
        logic [3:0]  cur_row;
        logic [3:0]  cur_col;
        frame_byte_t pending_bytes[$];
        int          fail_count;
        logic [7:0]  build_buf[$];
        logic [7:0]  build_sum;

        function void clear_state();
            columns_reg = 5'd16;
            rows_reg = 5'd10;
            cur_row = '0;
            cur_col = '0;
            pending_bytes.delete();
            fail_count = 0;
        endfunction

        function void set_reg(logic idx, logic [4:0] data);
            if (idx == REG_TEXT_COLUMNS)
                columns_reg = data;
            else
                rows_reg = data;
        endfunction

        function int limit_of(logic [4:0] v);
            if (v < 1)
                return 1;
            if (v > 16)
                return 16;
            return v;
        endfunction

        function void start_frame(logic [7:0] cmd);
            build_buf.delete();
            build_buf.push_back(cmd);
            build_sum = cmd;
        endfunction

        function void add(logic [7:0] b);
            build_buf.push_back(b);
            build_sum += b;
        endfunction

        function void add16(logic [15:0] v);
            add(v[15:8]);
            add(v[7:0]);
        endfunction

        // Wrap the command and payload with header, sum and trailer
        function void close_frame();
            frame_byte_t fb;
            fb.frame_end = 1'b0;
            fb.tx_byte = FRAME_SOF;
            pending_bytes.push_back(fb);
            fb.tx_byte = 8'(build_buf.size());
            pending_bytes.push_back(fb);
            foreach (build_buf[k])
            begin
                fb.tx_byte = build_buf[k];
                pending_bytes.push_back(fb);
            end
            fb.tx_byte = build_sum;
            pending_bytes.push_back(fb);
            fb.tx_byte = FRAME_EOF;
            fb.frame_end = 1'b1;
            pending_bytes.push_back(fb);
        endfunction

        function void advance_row();
            int r;
            r = cur_row + 1;
            if (r >= limit_of(rows_reg))
                r = 0;
            cur_row = 4'(r);
        endfunction

        // Note one accepted operation and queue its frame bytes
        function void note_operation(op_t op, logic [7:0] px, logic [7:0] py,
                                     logic [7:0] ex, logic [7:0] ey, logic [31:0] val,
                                     logic fl, logic [7:0] dc, logic [1:0] st);
            int c;
            case (op)
                OP_CHAR:
                    if (val[7:0] == NEWLINE_CHAR)
                    begin
                        cur_col = '0;
                        advance_row();
                    end
                    else
                    begin
                        start_frame(CMD_CHAR);
                        add16(16'(cur_col) * 16'd8);
                        add16(16'(cur_row) * 16'd16);
                        add(val[7:0]);
                        close_frame();
                        c = cur_col + 1;
                        if (c >= limit_of(columns_reg))
                        begin
                            c = 0;
                            advance_row();
                        end
                        cur_col = 4'(c);
                    end
                OP_CLEAR:
                begin
                    start_frame(CMD_CLEAR);
                    add(FRAME_SOF);
                    close_frame();
                    cur_row = '0;
                    cur_col = '0;
                end
                OP_BRIGHT:
                begin
                    start_frame(CMD_BRIGHT);
                    add16(val > BRIGHT_MAX ? BRIGHT_MAX[15:0] : val[15:0]);
                    close_frame();
                end
                OP_COLOR:
                begin
                    start_frame(CMD_COLOR);
                    add16(val[15:0]);
                    close_frame();
                end
                OP_BG:
                begin
                    start_frame(CMD_BG);
                    add(8'h01);
                    add16(val[15:0]);
                    close_frame();
                end
                OP_CLR_BG:
                begin
                    start_frame(CMD_BG);
                    add(8'h00);
                    add16(16'h0000);
                    close_frame();
                end
                OP_DOT:
                begin
                    start_frame(CMD_DOT);
                    add16({8'h00, px});
                    add16({8'h00, py});
                    close_frame();
                end
                OP_LINE, OP_BOX:
                begin
                    start_frame(op == OP_LINE ? CMD_LINE : (fl ? CMD_BOX_FILL : CMD_BOX));
                    add16({8'h00, px});
                    add16({8'h00, py});
                    add16({8'h00, ex});
                    add16({8'h00, ey});
                    close_frame();
                end
                OP_CIRCLE, OP_BMP:
                begin
                    start_frame(op == OP_BMP ? CMD_BMP : (fl ? CMD_CIRC_FILL : CMD_CIRC));
                    add16({8'h00, px});
                    add16({8'h00, py});
                    add16({8'h00, val[7:0]});
                    close_frame();
                end
                OP_BAUD:
                begin
                    start_frame(CMD_BAUD);
                    add16(val[31:16]);
                    add16(val[15:0]);
                    close_frame();
                end
                OP_NUM:
                begin
                    start_frame(CMD_NUM);
                    add16({8'h00, 8'(px * 8)});
                    add16({8'h00, 8'(py * 16)});
                    add16(val[31:16]);
                    add16(val[15:0]);
                    add(dc);
                    add({6'd0, st});
                    close_frame();
                end
                OP_LOCATE:
                begin
                    c = limit_of(rows_reg) - 1;
                    cur_row = 4'(py > c ? c : py);
                    c = limit_of(columns_reg) - 1;
                    cur_col = 4'(px > c ? c : px);
                end
                OP_NEWLINE:
                begin
                    cur_col = '0;
                    advance_row();
                end
                default: ;
            endcase
        endfunction

        // Compare one transferred byte against the oldest expectation
        function void check_byte(logic [7:0] tx, logic fe);
            frame_byte_t exp_b;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte tx_byte=%h frame_end=%b", tx, fe);
                fail_count++;
                return;
            end
            exp_b = pending_bytes.pop_front();
            if (tx !== exp_b.tx_byte)
            begin
                $error("tx_byte expected %h actual %h", exp_b.tx_byte, tx);
                fail_count++;
            end
            if (fe !== exp_b.frame_end)
            begin
                $error("frame_end expected %b actual %b", exp_b.frame_end, fe);
                fail_count++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [4:0] cfg_data;
    int         in_idle_pct;
    int         out_idle_pct;
    int         holdoff_cycles;
    int         cycle_count;
    frame_scoreboard sb;

    dcf_in_if  in_ch();
    dcf_out_if out_ch();

    display_command_framer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Check every output transfer
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_byte(out_ch.tx_byte, out_ch.frame_end);

    // Receiver readiness, with an optional long hold-off
    always @(negedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Offer one operation and hold it until transferred
    task automatic send_op(op_t op, logic [7:0] px, logic [7:0] py, logic [7:0] ex,
                           logic [7:0] ey, logic [31:0] val, logic fl,
                           logic [7:0] dc, logic [1:0] st);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.pos_x <= px;
        in_ch.pos_y <= py;
        in_ch.end_x <= ex;
        in_ch.end_y <= ey;
        in_ch.value <= val;
        in_ch.fill <= fl;
        in_ch.digit_count <= dc;
        in_ch.number_style <= st;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_operation(op, px, py, ex, ey, val, fl, dc, st);
        @(negedge clk);
    endtask

    task automatic send_random_op();
        op_t op;
        logic [31:0] val;
        op = op_t'($urandom_range(15));
        if ($urandom_range(3) == 0)
            op = OP_CHAR;
        val = $urandom;
        case ($urandom_range(5))
            0: val = 32'($urandom_range(600));
            1: val[7:0] = NEWLINE_CHAR;
            default: ;
        endcase
        send_op(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), val,
                1'($urandom), 8'($urandom), 2'($urandom_range(2)));
    endtask

    // Drop valid, wait until every expected byte has arrived, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        cycle_count = 0;
        holdoff_cycles = 0;
        in_idle_pct = 37;
        out_idle_pct = 77;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TEXT_COLUMNS;
        cfg_data = '0;
        out_ch.ready = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.end_x = '0;
        in_ch.end_y = '0;
        in_ch.value = '0;
        in_ch.fill = 1'b0;
        in_ch.digit_count = '0;
        in_ch.number_style = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every operation and the corner cases
        send_op(OP_CHAR, 0, 0, 0, 0, 32'h41, 0, 0, 0);
        send_op(OP_CHAR, 0, 0, 0, 0, 32'hFFFF_FF0A, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_BRIGHT, 0, 0, 0, 0, 32'd500, 0, 0, 0);
        send_op(OP_BRIGHT, 0, 0, 0, 0, 32'd501, 0, 0, 0);
        send_op(OP_BRIGHT, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_op(OP_COLOR, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_op(OP_BG, 0, 0, 0, 0, 32'h1234_ABCD, 0, 0, 0);
        send_op(OP_CLR_BG, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_DOT, 255, 255, 0, 0, 0, 0, 0, 0);
        send_op(OP_LINE, 0, 255, 255, 0, 0, 1, 0, 0);
        send_op(OP_BOX, 1, 2, 3, 4, 0, 0, 0, 0);
        send_op(OP_BOX, 255, 255, 255, 255, 0, 1, 0, 0);
        send_op(OP_CIRCLE, 10, 20, 0, 0, 32'hFF, 0, 0, 0);
        send_op(OP_CIRCLE, 10, 20, 0, 0, 32'h80, 1, 0, 0);
        send_op(OP_BMP, 7, 9, 0, 0, 32'hFFFF_FF03, 0, 0, 0);
        send_op(OP_BAUD, 0, 0, 0, 0, 32'd115200, 0, 0, 0);
        send_op(OP_NUM, 255, 255, 0, 0, 32'hFFFF_FFFF, 0, 255, 2);
        send_op(OP_NUM, 0, 0, 0, 0, 0, 0, 0, 1);
        send_op(OP_LOCATE, 255, 255, 0, 0, 0, 0, 0, 0);
        send_op(OP_CHAR, 0, 0, 0, 0, 32'h42, 0, 0, 0);
        send_op(OP_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Register extremes: zero and above-range values included
        write_reg(REG_TEXT_COLUMNS, 5'd1);
        write_reg(REG_TEXT_ROWS, 5'd1);
        repeat (25) send_random_op();
        drain();

        in_idle_pct = 77;
        out_idle_pct = 37;
        write_reg(REG_TEXT_COLUMNS, 5'd0);
        write_reg(REG_TEXT_ROWS, 5'd31);
        repeat (25) send_random_op();
        drain();

        // Long receiver hold-off while the sender keeps offering
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_reg(REG_TEXT_COLUMNS, 5'd3);
        write_reg(REG_TEXT_ROWS, 5'd16);
        holdoff_cycles = 200;
        repeat (30) send_random_op();
        drain();

        write_reg(REG_TEXT_COLUMNS, 5'd17);
        write_reg(REG_TEXT_ROWS, 5'd0);
        repeat (25) send_random_op();
        drain();

        write_reg(REG_TEXT_COLUMNS, 5'(($urandom_range(15)) + 1));
        write_reg(REG_TEXT_ROWS, 5'(($urandom_range(15)) + 1));
        repeat (32) send_random_op();
        drain();

        if (sb.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: filelist.f
sv/dcf_pkg.sv
sv/dcf_if.sv
sv/dcf_front.sv
sv/dcf_queue.sv
sv/dcf_back.sv
sv/display_command_framer_core.sv
tb/dcf_tb_if.sv
tb/tb_display_command_framer_core.sv
